@@ src/bpet_pkg.sv @@
// ----------------------------------------------------------------------------
// bpet_pkg
// Shared types and constants for the button press and encoder tracker.
// ----------------------------------------------------------------------------
package bpet_pkg;

    localparam int NUM_BUTTONS_DEF = 5;
    localparam int COUNT_WIDTH_DEF = 16;

    // fixed field widths of the item ports
    localparam int CMD_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 3;
    localparam int LOAD_W     = 16;
    localparam int CODE_W     = 2;
    localparam int ENC_OUT_W  = 16;
    localparam int HELD_W     = 5;
    localparam int HOLD_W     = 8;

    localparam int LEVEL_BIT0 = 3;
    localparam logic [HOLD_W-1:0] HOLD_MAX       = 8'hFF;
    localparam logic [HOLD_W-1:0] LONG_TICKS_RST = 8'd50;

    // APB register map
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic REG_LONG_TICKS = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_TAKE  = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [CODE_W-1:0] {
        PRESS_NONE  = 2'd0,
        PRESS_SHORT = 2'd1,
        PRESS_LONG  = 2'd2
    } t_press;

    // one-hot operation strobes, already qualified by the commit of an item
    typedef struct packed {
        logic tick;
        logic take;
        logic load;
        logic clr;
    } t_op;

endpackage

@@ src/button_press_and_encoder_tracker_top.sv @@
// The item is held in the input register after the edge that accepts it, then moves to
// the result register, where the receiver can take it.
// Throughput: one item per cycle. The input stalls only when both registers hold
// an item and the output is stalled.
// Reset: synchronous, active low; clears levels, hold counts, press codes,
// encoder count and pipeline valids; long_press_ticks returns to 50.
// ----------------------------------------------------------------------------
// button_press_and_encoder_tracker_top
// Button long/short press tracker and quadrature encoder counter, APB config.
// ----------------------------------------------------------------------------
module button_press_and_encoder_tracker_top
    import bpet_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [CMD_W-1:0]          i_command,
    input  logic [BYTE_W-1:0]         i_expander_byte,
    input  logic                      i_enc_data_pin,
    input  logic                      i_enc_clock_pin,
    input  logic [INDEX_W-1:0]        i_button_index,
    input  logic signed [LOAD_W-1:0]  i_encoder_load_value,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [CODE_W-1:0]         o_press_code,
    output logic signed [ENC_OUT_W-1:0] o_encoder_count,
    output logic [HELD_W-1:0]         o_held_mask,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready
);

    logic                     r_in_valid;
    t_cmd                     r_cmd;
    logic [BYTE_W-1:0]        r_byte;
    logic                     r_data_pin;
    logic                     r_clock_pin;
    logic [INDEX_W-1:0]       r_index;
    logic signed [LOAD_W-1:0] r_load;

    logic                     r_out_valid;
    logic [CODE_W-1:0]        r_code;
    logic [ENC_OUT_W-1:0]     r_count;
    logic [HELD_W-1:0]        r_held;

    logic [HOLD_W-1:0]        r_long_ticks;

    logic                     adv;
    logic                     accept;
    logic                     commit;
    t_op                      op;
    logic [CODE_W-1:0]        code;
    logic [ENC_OUT_W-1:0]     count_next;
    logic [HELD_W-1:0]        held_next;

    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !adv;
    assign accept     = i_in_valid && !o_in_stall;
    assign commit     = r_in_valid && adv;

    assign op.tick = commit && (r_cmd == CMD_TICK);
    assign op.take = commit && (r_cmd == CMD_TAKE);
    assign op.load = commit && (r_cmd == CMD_LOAD);
    assign op.clr  = commit && (r_cmd == CMD_CLEAR);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd       <= t_cmd'(i_command);
            r_byte      <= i_expander_byte;
            r_data_pin  <= i_enc_data_pin;
            r_clock_pin <= i_enc_clock_pin;
            r_index     <= i_button_index;
            r_load      <= i_encoder_load_value;
        end
    end

    bpet_btn #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_btn (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_byte       (r_byte),
        .i_index      (r_index),
        .i_long_ticks (r_long_ticks),
        .o_code       (code),
        .o_held_next  (held_next)
    );

    bpet_enc #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_enc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_data_pin   (r_data_pin),
        .i_clock_pin  (r_clock_pin),
        .i_load       (r_load),
        .o_count_next (count_next)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= commit || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_code  <= code;
            r_count <= count_next;
            r_held  <= held_next;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_press_code    = r_code;
    assign o_encoder_count = r_count;
    assign o_held_mask     = r_held;

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks <= LONG_TICKS_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr[PADDR_W-1] == REG_LONG_TICKS) begin
            r_long_ticks <= pwdata[HOLD_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_LONG_TICKS) ? PDATA_W'(r_long_ticks) : '0;

    // checks
    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_press_code == PRESS_NONE || o_press_code == PRESS_SHORT
                         || o_press_code == PRESS_LONG))
        else $error("illegal press code on output");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with free pipeline");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("held result dropped");

    a_code_only_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_cmd != CMD_TAKE) |=> (o_press_code == PRESS_NONE))
        else $error("press code on non-take item");

endmodule

@@ src/bpet_btn.sv @@
// ----------------------------------------------------------------------------
// bpet_btn
// Button bank: levels, hold counters and pending press codes per button.
// ----------------------------------------------------------------------------
module bpet_btn
    import bpet_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_op                 i_op,
    input  logic [BYTE_W-1:0]   i_byte,
    input  logic [INDEX_W-1:0]  i_index,
    input  logic [HOLD_W-1:0]   i_long_ticks,
    output logic [CODE_W-1:0]   o_code,
    output logic [HELD_W-1:0]   o_held_next
);

    logic [NUM_BUTTONS-1:0] r_level;
    logic [NUM_BUTTONS-1:0] n_level;
    logic [NUM_BUTTONS-1:0] lvl_in;
    logic [HOLD_W-1:0]      r_hold [NUM_BUTTONS];
    logic [HOLD_W-1:0]      n_hold [NUM_BUTTONS];
    logic [CODE_W-1:0]      r_pend [NUM_BUTTONS];
    logic [CODE_W-1:0]      n_pend [NUM_BUTTONS];

    // button levels sit at byte bits 3 and up; positions past bit 7 read as up
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lvl
        if (LEVEL_BIT0 + g < BYTE_W) begin : g_bit
            assign lvl_in[g] = i_byte[LEVEL_BIT0+g];
        end else begin : g_none
            assign lvl_in[g] = 1'b0;
        end
    end

    always_comb begin
        logic [HOLD_W-1:0] hold_tmp;
        n_level = r_level;
        o_code  = PRESS_NONE;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            n_hold[i] = r_hold[i];
            n_pend[i] = r_pend[i];
            hold_tmp  = r_hold[i];
            if (i_op.tick) begin
                if (!lvl_in[i] && r_level[i]) begin
                    if (r_hold[i] > i_long_ticks) begin
                        n_pend[i] = PRESS_LONG;
                    end else if (r_pend[i] == PRESS_NONE) begin
                        n_pend[i] = PRESS_SHORT;
                    end
                    hold_tmp = '0;
                end
                if (lvl_in[i] && hold_tmp != HOLD_MAX) begin
                    hold_tmp = hold_tmp + 1'b1;
                end
                n_hold[i] = hold_tmp;
            end else if (i_op.take) begin
                if (i_index == INDEX_W'(i)) begin
                    o_code    = r_pend[i];
                    n_pend[i] = PRESS_NONE;
                end
            end else if (i_op.clr) begin
                n_hold[i] = '0;
                n_pend[i] = PRESS_NONE;
            end
        end
        if (i_op.tick) begin
            n_level = lvl_in;
        end else if (i_op.clr) begin
            n_level = '0;
        end
    end

    assign o_held_next = HELD_W'(n_level);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_hold[i] <= '0;
                r_pend[i] <= PRESS_NONE;
            end
        end else begin
            r_level <= n_level;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_hold[i] <= n_hold[i];
                r_pend[i] <= n_pend[i];
            end
        end
    end

endmodule

@@ src/bpet_enc.sv @@
// ----------------------------------------------------------------------------
// bpet_enc
// Quadrature encoder counter with load.
// ----------------------------------------------------------------------------
module bpet_enc
    import bpet_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_op                      i_op,
    input  logic                     i_data_pin,
    input  logic                     i_clock_pin,
    input  logic signed [LOAD_W-1:0] i_load,
    output logic [ENC_OUT_W-1:0]     o_count_next
);

    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   r_clk_prev;
    logic                   n_clk_prev;

    always_comb begin
        n_count    = r_count;
        n_clk_prev = r_clk_prev;
        if (i_op.tick) begin
            n_clk_prev = i_clock_pin;
            if (i_clock_pin != r_clk_prev) begin
                // clock equal to data steps down
                if (i_clock_pin == i_data_pin) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
        end else if (i_op.load) begin
            n_count = COUNT_WIDTH'(i_load);
        end
    end

    assign o_count_next = ENC_OUT_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_clk_prev <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_clk_prev <= n_clk_prev;
        end
    end

endmodule

@@ verif/button_press_and_encoder_tracker_top_tb.sv @@
// ----------------------------------------------------------------------------
// button_press_and_encoder_tracker_top_tb
// Self-checking bench for the button press and encoder tracker. Commands go
// in through the valid/stall input channel. An item-level model of the
// tracker predicts every result, and each result is checked field by field
// in arrival order. Directed cases come first: button and encoder extremes,
// press thresholds and back-pressure. A long random run follows, split into
// phases with different thresholds, with random sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module button_press_and_encoder_tracker_top_tb;
    import bpet_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB          = NUM_BUTTONS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 6;
    localparam logic [PADDR_W-1:0] LONG_TICKS_ADDR = PADDR_W'(4 * REG_LONG_TICKS);

    typedef struct {
        t_cmd                   cmd;
        logic [BYTE_W-1:0]      exp_byte;
        logic                   enc_data;
        logic                   enc_clk;
        logic [INDEX_W-1:0]     btn_idx;
        logic signed [LOAD_W-1:0] load_val;
    } t_tracker_cmd;

    typedef struct {
        t_press                     code;
        logic signed [ENC_OUT_W-1:0] count;
        logic [HELD_W-1:0]          held;
    } t_tracker_out;

    // DUT signals
    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [CMD_W-1:0]           i_command;
    logic [BYTE_W-1:0]          i_expander_byte;
    logic                       i_enc_data_pin;
    logic                       i_enc_clock_pin;
    logic [INDEX_W-1:0]         i_button_index;
    logic signed [LOAD_W-1:0]   i_encoder_load_value;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [CODE_W-1:0]          o_press_code;
    logic signed [ENC_OUT_W-1:0] o_encoder_count;
    logic [HELD_W-1:0]          o_held_mask;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_W-1:0]         paddr;
    logic [PDATA_W-1:0]         pwdata;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    // predicted tracker state
    logic [HOLD_W-1:0]          thr;
    logic [NB-1:0]              lvl_model;
    logic [HOLD_W-1:0]          hold_ticks [NB];
    t_press                     press_waiting [NB];
    logic                       enc_clk_last;
    logic [ENC_OUT_W-1:0]       enc_count;

    t_tracker_out               expected_outputs [$];

    // bench bookkeeping
    int     err_count;
    int     items_sent;
    int     results_checked;
    int     long_taken;
    int     short_taken;
    int     in_stall_cycles;
    int     cycles;
    int     hold_off;
    int     burst_left;
    bit     gaps_on;

    // random stimulus state
    logic [NB-1:0]  sim_buttons;
    int             flip_pct;
    int             enc_phase;
    int             enc_dir;

    button_press_and_encoder_tracker_top u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_command            (i_command),
        .i_expander_byte      (i_expander_byte),
        .i_enc_data_pin       (i_enc_data_pin),
        .i_enc_clock_pin      (i_enc_clock_pin),
        .i_button_index       (i_button_index),
        .i_encoder_load_value (i_encoder_load_value),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_press_code         (o_press_code),
        .o_encoder_count      (o_encoder_count),
        .o_held_mask          (o_held_mask),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (i_in_valid && o_in_stall)
            in_stall_cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d results outstanding", cycles,
                     expected_outputs.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tracker model: applies one command, returns the result it produces
    // ------------------------------------------------------------------
    function automatic t_tracker_out track_apply(t_tracker_cmd c);
        t_tracker_out r;
        logic [NB-1:0] lv_new;
        logic now_dn;
        r.code = PRESS_NONE;
        lv_new = '0;
        case (c.cmd)
            CMD_TICK: begin
                for (int i = 0; i < NB; i++) begin
                    // buttons whose bit would lie past the byte read as up
                    now_dn = (LEVEL_BIT0 + i < BYTE_W) ? c.exp_byte[LEVEL_BIT0 + i] : 1'b0;
                    if (!now_dn && lvl_model[i]) begin
                        if (hold_ticks[i] > thr)
                            press_waiting[i] = PRESS_LONG;
                        else if (press_waiting[i] == PRESS_NONE)
                            press_waiting[i] = PRESS_SHORT;
                        hold_ticks[i] = '0;
                    end
                    if (now_dn && hold_ticks[i] != HOLD_MAX)
                        hold_ticks[i] = hold_ticks[i] + 1'b1;
                    lv_new[i] = now_dn;
                end
                lvl_model = lv_new;
                if (c.enc_clk != enc_clk_last)
                    enc_count = (c.enc_clk == c.enc_data) ? enc_count - 1'b1
                                                          : enc_count + 1'b1;
                enc_clk_last = c.enc_clk;
            end
            CMD_TAKE: begin
                if (c.btn_idx < NB) begin
                    r.code = press_waiting[c.btn_idx];
                    press_waiting[c.btn_idx] = PRESS_NONE;
                    if (r.code == PRESS_LONG)
                        long_taken++;
                    else if (r.code == PRESS_SHORT)
                        short_taken++;
                end
            end
            CMD_LOAD: begin
                enc_count = c.load_val;
            end
            default: begin
                lvl_model = '0;
                for (int i = 0; i < NB; i++) begin
                    hold_ticks[i] = '0;
                    press_waiting[i] = PRESS_NONE;
                end
            end
        endcase
        r.count = enc_count;
        r.held = HELD_W'(lvl_model);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH result %0d %s: got %0d expected %0d (t=%0t)",
                 results_checked, what, got, want, $realtime);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_tracker_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_outputs.size() == 0) begin
                report_mismatch("unexpected result", int'(o_encoder_count), 0);
            end else begin
                want = expected_outputs.pop_front();
                if (o_press_code !== want.code)
                    report_mismatch("press_code", int'(o_press_code), int'(want.code));
                if (o_encoder_count !== want.count)
                    report_mismatch("encoder_count", int'(o_encoder_count), int'(want.count));
                if (o_held_mask !== want.held)
                    report_mismatch("held_mask", int'(o_held_mask), int'(want.held));
            end
            results_checked++;
        end
    end

    // receiver: stall phases of random density, or a counted hold-off
    initial begin
        int phase_left;
        int stall_pct;
        phase_left = 0;
        stall_pct = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                i_out_stall <= 1'b1;
                hold_off--;
            end else begin
                if (phase_left == 0) begin
                    phase_left = $urandom_range(5, 60);
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 20;
                        3:       stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                phase_left--;
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks: called at a falling edge, return at a falling edge
    // ------------------------------------------------------------------
    task automatic send_command(t_tracker_cmd c);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        i_in_valid           <= 1'b1;
        i_command            <= c.cmd;
        i_expander_byte      <= c.exp_byte;
        i_enc_data_pin       <= c.enc_data;
        i_enc_clock_pin      <= c.enc_clk;
        i_button_index       <= c.btn_idx;
        i_encoder_load_value <= c.load_val;
        do @(posedge i_clk); while (o_in_stall);
        expected_outputs.push_back(track_apply(c));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic cfg_write_threshold(logic [HOLD_W-1:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LONG_TICKS_ADDR;
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        thr = value;
        @(negedge i_clk);
        // read back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== PDATA_W'(value))
            report_mismatch("long_press_ticks readback", int'(prdata), int'(value));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // item builders: fields the command ignores carry random values
    function automatic t_tracker_cmd any_cmd(t_cmd op);
        t_tracker_cmd c;
        c.cmd      = op;
        c.exp_byte = BYTE_W'($urandom);
        c.enc_data = 1'($urandom);
        c.enc_clk  = 1'($urandom);
        c.btn_idx  = INDEX_W'($urandom);
        c.load_val = LOAD_W'($urandom);
        return c;
    endfunction

    function automatic t_tracker_cmd tick_cmd(logic [BYTE_W-1:0] b, logic d, logic k);
        t_tracker_cmd c;
        c = any_cmd(CMD_TICK);
        c.exp_byte = b;
        c.enc_data = d;
        c.enc_clk  = k;
        return c;
    endfunction

    function automatic t_tracker_cmd take_cmd(int idx);
        t_tracker_cmd c;
        c = any_cmd(CMD_TAKE);
        c.btn_idx = INDEX_W'(idx);
        return c;
    endfunction

    function automatic t_tracker_cmd load_cmd(logic [LOAD_W-1:0] v);
        t_tracker_cmd c;
        c = any_cmd(CMD_LOAD);
        c.load_val = v;
        return c;
    endfunction

    // ticks that keep the encoder clock where it is
    task automatic hold_ticks_for(logic [BYTE_W-1:0] b, int n);
        for (int i = 0; i < n; i++)
            send_command(tick_cmd(b, enc_clk_last, enc_clk_last));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        gaps_on = 1'b0;
        // all buttons and the unused low bits down, encoder clock rises
        send_command(tick_cmd(8'hFF, 1'b0, 1'b1));
        // release all: short press on every button
        send_command(tick_cmd(8'h07, 1'b1, 1'b1));
        for (int i = 0; i < NB; i++)
            send_command(take_cmd(i));
        // out-of-range indexes take nothing
        for (int i = NB; i < 8; i++)
            send_command(take_cmd(i));
        send_command(take_cmd(0));
        // count wraps upward and downward
        send_command(load_cmd(16'h7FFF));
        send_command(tick_cmd(8'h00, 1'b1, 1'b0));
        send_command(load_cmd(16'h8000));
        send_command(tick_cmd(8'h00, 1'b0, 1'b1));
        send_command(tick_cmd(8'h00, 1'b0, 1'b0));
        send_command(tick_cmd(8'h00, 1'b1, 1'b1));
        send_command(load_cmd(16'hFFFF));
        send_command(tick_cmd(8'h00, 1'b1, 1'b0));
        // clear drops held levels, so no release follows
        send_command(tick_cmd(8'h08, 1'b1, 1'b0));
        send_command(any_cmd(CMD_CLEAR));
        send_command(tick_cmd(8'h00, 1'b1, 1'b0));
        send_command(take_cmd(0));
        wait_idle();
    endtask

    task automatic test_thresholds();
        gaps_on = 1'b1;
        // zero threshold: one tick of hold is already long
        cfg_write_threshold(8'd0);
        hold_ticks_for(8'h80, 1);
        hold_ticks_for(8'h00, 1);
        // a later short press does not overwrite a waiting long one
        hold_ticks_for(8'h80, 1);
        cfg_write_threshold(8'd10);
        hold_ticks_for(8'h00, 1);
        send_command(take_cmd(4));
        // exactly at the threshold is short, one above is long
        cfg_write_threshold(LONG_TICKS_RST);
        hold_ticks_for(8'h10, 50);
        hold_ticks_for(8'h00, 1);
        send_command(take_cmd(1));
        hold_ticks_for(8'h10, 51);
        hold_ticks_for(8'h00, 1);
        send_command(take_cmd(1));
        // hold count saturates; above 254 still long
        cfg_write_threshold(8'd254);
        hold_ticks_for(8'h20, 260);
        hold_ticks_for(8'h00, 1);
        send_command(take_cmd(2));
        // threshold at maximum: never long
        cfg_write_threshold(8'hFF);
        hold_ticks_for(8'h40, 260);
        hold_ticks_for(8'h00, 1);
        send_command(take_cmd(3));
        cfg_write_threshold(LONG_TICKS_RST);
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_off = 300;
        for (int i = 0; i < 40; i++)
            send_command(i % 7 == 6 ? take_cmd(i % NB)
                                    : tick_cmd(BYTE_W'($urandom), 1'($urandom), 1'($urandom)));
        wait_idle();
    endtask

    task automatic test_pause();
        gaps_on = 1'b1;
        for (int n = 0; n < 3; n++) begin
            for (int i = 0; i < 12; i++)
                send_command(tick_cmd(BYTE_W'($urandom), 1'($urandom), 1'($urandom)));
            send_command(take_cmd($urandom_range(0, NB - 1)));
            // sender holds until every result is back
            wait_idle();
        end
    endtask

    function automatic t_tracker_cmd random_cmd();
        t_tracker_cmd c;
        int r;
        r = $urandom_range(0, 99);
        if (r < 72) begin
            for (int i = 0; i < NB; i++)
                if ($urandom_range(0, 99) < flip_pct)
                    sim_buttons[i] = ~sim_buttons[i];
            if ($urandom_range(0, 9) == 0)
                enc_dir = -enc_dir;
            if ($urandom_range(0, 99) < 30)
                enc_phase = (enc_phase + enc_dir + 4) % 4;
            // quadrature order of (clock, data): 00 10 11 01
            c = tick_cmd({sim_buttons, 3'($urandom)}, enc_phase[0] ^ enc_phase[1],
                         enc_phase[0] ^ (enc_phase[1] & ~enc_phase[0]) | enc_phase[1] & enc_phase[0]);
            c.enc_clk  = (enc_phase == 1 || enc_phase == 2);
            c.enc_data = (enc_phase == 2 || enc_phase == 3);
            if ($urandom_range(0, 99) < 8)
                c = tick_cmd(BYTE_W'($urandom), 1'($urandom), 1'($urandom));
        end else if (r < 90) begin
            c = take_cmd($urandom_range(0, 99) < 6 ? $urandom_range(NB, 7)
                                                  : $urandom_range(0, NB - 1));
        end else if (r < 94) begin
            case ($urandom_range(0, 5))
                0:       c = load_cmd(16'h7FFF);
                1:       c = load_cmd(16'h8000);
                2:       c = load_cmd(16'hFFFF);
                3:       c = load_cmd(16'h0000);
                default: c = load_cmd(LOAD_W'($urandom));
            endcase
        end else begin
            c = any_cmd(CMD_CLEAR);
            sim_buttons = '0;
        end
        return c;
    endfunction

    task automatic test_random(int total);
        logic [HOLD_W-1:0] t;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       t = HOLD_W'($urandom_range(0, 8));
                1:       t = LONG_TICKS_RST;
                2:       t = HOLD_W'($urandom_range(0, 254));
                default: t = HOLD_W'($urandom_range(0, 30));
            endcase
            cfg_write_threshold(t);
            flip_pct = (ph == 1) ? 2 : $urandom_range(3, 20);
            gaps_on = ph[0];
            for (int i = 0; i < total / 4; i++)
                send_command(random_cmd());
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    initial begin
        i_rst_n              = 1'b0;
        i_in_valid           = 1'b0;
        i_command            = CMD_TICK;
        i_expander_byte      = '0;
        i_enc_data_pin       = 1'b0;
        i_enc_clock_pin      = 1'b0;
        i_button_index       = '0;
        i_encoder_load_value = '0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        err_count            = 0;
        items_sent           = 0;
        results_checked      = 0;
        long_taken           = 0;
        short_taken          = 0;
        in_stall_cycles      = 0;
        cycles               = 0;
        hold_off             = 0;
        burst_left           = 0;
        gaps_on              = 1'b0;
        sim_buttons          = '0;
        flip_pct             = 10;
        enc_phase            = 0;
        enc_dir              = 1;
        thr                  = LONG_TICKS_RST;
        lvl_model            = '0;
        enc_clk_last         = 1'b0;
        enc_count            = '0;
        for (int i = 0; i < NB; i++) begin
            hold_ticks[i]    = '0;
            press_waiting[i] = PRESS_NONE;
        end

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_thresholds();
        test_backpressure();
        test_pause();
        test_random(300);

        wait_idle();
        if (expected_outputs.size() != 0)
            report_mismatch("results never arrived", 0, expected_outputs.size());
        $display("Checked %0d results from %0d items; %0d short and %0d long presses taken.",
                 results_checked, items_sent, short_taken, long_taken);
        $display("Input stalled on %0d cycles; %0d mismatches.", in_stall_cycles, err_count);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
src/bpet_pkg.sv
src/bpet_btn.sv
src/bpet_enc.sv
src/button_press_and_encoder_tracker_top.sv
verif/button_press_and_encoder_tracker_top_tb.sv
